// ----- src/tekd_pkg.sv -----
// Package for the terminal escape key decoder: field widths, byte codes,
// modifier codes, the key sequence table and the match result type.
// No dependencies.
package tekd_pkg;

	localparam int BYTE_W       = 8;
	localparam int MODS_W       = 3;
	localparam int ENTRY_COUNT  = 78;
	localparam int ENTRY_SLOTS  = 8;
	localparam int POS_W        = $clog2(ENTRY_SLOTS);
	localparam int IDX_W        = $clog2(ENTRY_COUNT);

	localparam logic [BYTE_W-1:0] ESC_B   = 8'h1B;
	localparam logic [BYTE_W-1:0] DEL_B   = 8'h7F;
	localparam logic [BYTE_W-1:0] NUL_B   = 8'h00;
	localparam logic [BYTE_W-1:0] CSI_B   = 8'h5B;
	localparam logic [BYTE_W-1:0] SS3_B   = 8'h4F;
	localparam logic [BYTE_W-1:0] TILDE_B = 8'h7E;
	localparam logic [BYTE_W-1:0] SEMI_B  = 8'h3B;
	localparam logic [BYTE_W-1:0] PAD_B   = 8'h00;

	localparam logic [MODS_W-1:0] MOD_NONE  = 3'd0;
	localparam logic [MODS_W-1:0] MOD_SHIFT = 3'd1;
	localparam logic [MODS_W-1:0] MOD_CTRL  = 3'd2;
	localparam logic [MODS_W-1:0] MOD_ALT   = 3'd4;

	// Modifier parameter digits inside a sequence
	localparam logic [BYTE_W-1:0] DIG_SHIFT = 8'h32;
	localparam logic [BYTE_W-1:0] DIG_ALT   = 8'h33;
	localparam logic [BYTE_W-1:0] DIG_CTRL  = 8'h35;

	typedef struct packed {
		logic [BYTE_W-1:0]                    code;
		logic [MODS_W-1:0]                    mods;
		logic [POS_W-1:0]                     len;
		logic [0:ENTRY_SLOTS-1][BYTE_W-1:0]   b;
	} key_entry_t;

	typedef struct packed {
		logic                   found;
		logic                   complete;
		logic [BYTE_W-1:0]      code;
		logic [MODS_W-1:0]      mods;
		logic [ENTRY_COUNT-1:0] alive;
	} match_t;

	typedef logic [BYTE_W-1:0] byte_t;

	function automatic key_entry_t ent(byte_t k, logic [MODS_W-1:0] m, logic [POS_W-1:0] n,
			logic [0:ENTRY_SLOTS-1][BYTE_W-1:0] s);
		key_entry_t e;
		e.code = k;
		e.mods = m;
		e.len  = n;
		e.b    = s;
		return e;
	endfunction

	// ESC O c and ESC O d c
	function automatic key_entry_t ss3_plain(byte_t k, logic [MODS_W-1:0] m, byte_t c);
		return ent(k, m, 3'd3, {ESC_B, SS3_B, c, PAD_B, PAD_B, PAD_B, PAD_B, PAD_B});
	endfunction

	function automatic key_entry_t ss3_mod(byte_t k, logic [MODS_W-1:0] m, byte_t d, byte_t c);
		return ent(k, m, 3'd4, {ESC_B, SS3_B, d, c, PAD_B, PAD_B, PAD_B, PAD_B});
	endfunction

	// ESC [ d1 d2 ~ and ESC [ d1 d2 ; d ~
	function automatic key_entry_t csi_plain(byte_t k, byte_t d1, byte_t d2);
		return ent(k, MOD_NONE, 3'd5, {ESC_B, CSI_B, d1, d2, TILDE_B, PAD_B, PAD_B, PAD_B});
	endfunction

	function automatic key_entry_t csi_mod(byte_t k, logic [MODS_W-1:0] m, byte_t d1, byte_t d2,
			byte_t d);
		return ent(k, m, 3'd7, {ESC_B, CSI_B, d1, d2, SEMI_B, d, TILDE_B, PAD_B});
	endfunction

	// ESC [ d ~ and ESC [ d ; e ~
	function automatic key_entry_t csi_short(byte_t k, byte_t d);
		return ent(k, MOD_NONE, 3'd4, {ESC_B, CSI_B, d, TILDE_B, PAD_B, PAD_B, PAD_B, PAD_B});
	endfunction

	function automatic key_entry_t csi_short_mod(byte_t k, logic [MODS_W-1:0] m, byte_t d,
			byte_t e);
		return ent(k, m, 3'd6, {ESC_B, CSI_B, d, SEMI_B, e, TILDE_B, PAD_B, PAD_B});
	endfunction

	// ESC [ 1 ; d f
	function automatic key_entry_t mod_key(byte_t k, logic [MODS_W-1:0] m, byte_t d, byte_t f);
		return ent(k, m, 3'd6, {ESC_B, CSI_B, 8'h31, SEMI_B, d, f, PAD_B, PAD_B});
	endfunction

	// ESC [ c
	function automatic key_entry_t csi3(byte_t k, logic [MODS_W-1:0] m, byte_t c);
		return ent(k, m, 3'd3, {ESC_B, CSI_B, c, PAD_B, PAD_B, PAD_B, PAD_B, PAD_B});
	endfunction

	// Key sequences in priority order: the lowest matching index decides
	localparam key_entry_t KEY_TABLE [ENTRY_COUNT] = '{
		ss3_plain(8'h70, MOD_NONE, 8'h50), ss3_mod(8'h70, MOD_CTRL, DIG_CTRL, 8'h50),
		ss3_mod(8'h70, MOD_SHIFT, DIG_SHIFT, 8'h50), ss3_mod(8'h70, MOD_ALT, DIG_ALT, 8'h50),
		ss3_plain(8'h71, MOD_NONE, 8'h51), ss3_mod(8'h71, MOD_CTRL, DIG_CTRL, 8'h51),
		ss3_mod(8'h71, MOD_SHIFT, DIG_SHIFT, 8'h51), ss3_mod(8'h71, MOD_ALT, DIG_ALT, 8'h51),
		ss3_plain(8'h72, MOD_NONE, 8'h52), ss3_mod(8'h72, MOD_CTRL, DIG_CTRL, 8'h52),
		ss3_mod(8'h72, MOD_SHIFT, DIG_SHIFT, 8'h52), ss3_mod(8'h72, MOD_ALT, DIG_ALT, 8'h52),
		ss3_plain(8'h73, MOD_NONE, 8'h53), ss3_mod(8'h73, MOD_CTRL, DIG_CTRL, 8'h53),
		ss3_mod(8'h73, MOD_SHIFT, DIG_SHIFT, 8'h53), ss3_mod(8'h73, MOD_ALT, DIG_ALT, 8'h53),
		csi_plain(8'h74, 8'h31, 8'h35), csi_mod(8'h74, MOD_CTRL, 8'h31, 8'h35, DIG_CTRL),
		csi_mod(8'h74, MOD_SHIFT, 8'h31, 8'h35, DIG_SHIFT),
		csi_mod(8'h74, MOD_ALT, 8'h31, 8'h35, DIG_ALT),
		csi_plain(8'h75, 8'h31, 8'h37), csi_mod(8'h75, MOD_CTRL, 8'h31, 8'h37, DIG_CTRL),
		csi_mod(8'h75, MOD_SHIFT, 8'h31, 8'h37, DIG_SHIFT),
		csi_mod(8'h75, MOD_ALT, 8'h31, 8'h37, DIG_ALT),
		csi_plain(8'h76, 8'h31, 8'h38), csi_mod(8'h76, MOD_CTRL, 8'h31, 8'h38, DIG_CTRL),
		csi_mod(8'h76, MOD_SHIFT, 8'h31, 8'h38, DIG_SHIFT),
		csi_mod(8'h76, MOD_ALT, 8'h31, 8'h38, DIG_ALT),
		csi_plain(8'h77, 8'h31, 8'h39), csi_mod(8'h77, MOD_CTRL, 8'h31, 8'h39, DIG_CTRL),
		csi_mod(8'h77, MOD_SHIFT, 8'h31, 8'h39, DIG_SHIFT),
		csi_mod(8'h77, MOD_ALT, 8'h31, 8'h39, DIG_ALT),
		csi_plain(8'h78, 8'h32, 8'h30), csi_mod(8'h78, MOD_CTRL, 8'h32, 8'h30, DIG_CTRL),
		csi_mod(8'h78, MOD_SHIFT, 8'h32, 8'h30, DIG_SHIFT),
		csi_mod(8'h78, MOD_ALT, 8'h32, 8'h30, DIG_ALT),
		csi_plain(8'h79, 8'h32, 8'h31), csi_mod(8'h79, MOD_CTRL, 8'h32, 8'h31, DIG_CTRL),
		csi_mod(8'h79, MOD_SHIFT, 8'h32, 8'h31, DIG_SHIFT),
		csi_mod(8'h79, MOD_ALT, 8'h32, 8'h31, DIG_ALT),
		csi_plain(8'h7A, 8'h32, 8'h33), csi_mod(8'h7A, MOD_CTRL, 8'h32, 8'h33, DIG_CTRL),
		csi_mod(8'h7A, MOD_SHIFT, 8'h32, 8'h33, DIG_SHIFT),
		csi_mod(8'h7A, MOD_ALT, 8'h32, 8'h33, DIG_ALT),
		csi_plain(8'h7B, 8'h32, 8'h34), csi_mod(8'h7B, MOD_CTRL, 8'h32, 8'h34, DIG_CTRL),
		csi_mod(8'h7B, MOD_SHIFT, 8'h32, 8'h34, DIG_SHIFT),
		csi_mod(8'h7B, MOD_ALT, 8'h32, 8'h34, DIG_ALT),
		csi_short(8'h24, 8'h31),
		mod_key(8'h24, MOD_CTRL, DIG_CTRL, 8'h48), mod_key(8'h24, MOD_SHIFT, DIG_SHIFT, 8'h48),
		mod_key(8'h24, MOD_ALT, DIG_ALT, 8'h48),
		csi_short(8'h2D, 8'h32), csi_short_mod(8'h2D, MOD_CTRL, 8'h32, DIG_CTRL),
		csi_short(8'h2E, 8'h33), csi_short_mod(8'h2E, MOD_CTRL, 8'h33, DIG_CTRL),
		csi_short_mod(8'h2E, MOD_SHIFT, 8'h33, DIG_SHIFT),
		csi_short(8'h21, 8'h35), csi_short_mod(8'h21, MOD_CTRL, 8'h35, DIG_CTRL),
		csi_short_mod(8'h21, MOD_ALT, 8'h35, DIG_ALT),
		csi_short(8'h22, 8'h36), csi_short_mod(8'h22, MOD_CTRL, 8'h36, DIG_CTRL),
		csi_short_mod(8'h22, MOD_ALT, 8'h36, DIG_ALT),
		ss3_plain(8'h23, MOD_NONE, 8'h46),
		mod_key(8'h23, MOD_CTRL, DIG_CTRL, 8'h46), mod_key(8'h23, MOD_SHIFT, DIG_SHIFT, 8'h46),
		mod_key(8'h23, MOD_ALT, DIG_ALT, 8'h46),
		csi3(8'h26, MOD_NONE, 8'h41), mod_key(8'h26, MOD_CTRL, DIG_CTRL, 8'h41),
		csi3(8'h28, MOD_NONE, 8'h42), mod_key(8'h28, MOD_CTRL, DIG_CTRL, 8'h42),
		csi3(8'h27, MOD_NONE, 8'h43), mod_key(8'h27, MOD_CTRL, DIG_CTRL, 8'h43),
		csi3(8'h25, MOD_NONE, 8'h44), mod_key(8'h25, MOD_CTRL, DIG_CTRL, 8'h44),
		ss3_plain(8'h0D, MOD_SHIFT, 8'h4D),
		ent(8'h0D, MOD_ALT, 3'd2, {ESC_B, 8'h0D, PAD_B, PAD_B, PAD_B, PAD_B, PAD_B, PAD_B}),
		csi3(8'h09, MOD_SHIFT, 8'h5A)
	};

endpackage

// ----- src/tekd_if.sv -----
// Stream interfaces for the terminal escape key decoder: received bytes in,
// decoded keys out. Depends on tekd_pkg.
interface tekd_rx_if;
	logic                           valid;
	logic                           ready;
	logic [tekd_pkg::BYTE_W-1:0]    rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface tekd_key_if;
	logic                           valid;
	logic                           ready;
	logic [tekd_pkg::BYTE_W-1:0]    key_code;
	logic [tekd_pkg::MODS_W-1:0]    modifiers;

	modport source (output valid, output key_code, output modifiers, input ready);
	modport sink (input valid, input key_code, input modifiers, output ready);
endinterface

// ----- src/terminal_escape_key_decoder_top.sv -----
// Top level of the terminal escape key decoder: input register, table match
// and result register. Depends on tekd_pkg, tekd_if and tekd_match.

// Decodes a terminal byte stream into key codes with modifiers, one received
// byte per request. Plain bytes pass through with no modifier, NUL and DEL
// outside a sequence are dropped, and ESC opens a sequence that is matched
// against a table of 78 function, navigation and arrow key sequences; a full
// match gives one key, a partial match waits, and a failing byte comes out as
// a plain key. The block accepts one byte every cycle unless it is stalled. An
// accepted byte is held in the input register, and the combinational compare
// against the running 78-entry match mask feeds the result register, which
// presents the key. Backpressure on the key side stalls the input only while
// the result register is full and not taken.
module terminal_escape_key_decoder_top #(
	parameter int MAX_SEQ_LEN = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	tekd_rx_if.sink           rx,
	tekd_key_if.source        keys
);

	localparam int LEN_W = $clog2(MAX_SEQ_LEN + 1);

	logic                             valid_s1;
	logic [tekd_pkg::BYTE_W-1:0]      rx_byte_s1;
	logic                             valid_s2;
	logic [tekd_pkg::BYTE_W-1:0]      key_code_s2;
	logic [tekd_pkg::MODS_W-1:0]      mods_s2;
	logic [LEN_W-1:0]                 len_q;
	logic [tekd_pkg::ENTRY_COUNT-1:0] alive_q;

	logic                             out_free;
	logic                             advance;
	logic                             emit;
	logic [tekd_pkg::BYTE_W-1:0]      code_d;
	logic [tekd_pkg::MODS_W-1:0]      mods_d;
	logic [LEN_W-1:0]                 len_d;
	logic [tekd_pkg::ENTRY_COUNT-1:0] alive_d;
	tekd_pkg::match_t                 m;

	// Handshake: the byte in stage 1 moves on whenever the result slot is free
	assign out_free = !valid_s2 || keys.ready;
	assign advance  = valid_s1 && out_free;
	assign rx.ready = !valid_s1 || out_free;

	tekd_match u_match (
		.rx_byte (rx_byte_s1),
		.pos     (len_q[tekd_pkg::POS_W-1:0]),
		.alive   (alive_q),
		.res     (m)
	);

	// Decide the next sequence state and the key to emit
	always_comb begin
		len_d   = len_q;
		alive_d = alive_q;
		emit    = 1'b0;
		code_d  = rx_byte_s1;
		mods_d  = tekd_pkg::MOD_NONE;
		if (len_q == '0) begin
			if (rx_byte_s1 == tekd_pkg::ESC_B) begin
				if (MAX_SEQ_LEN > 1) begin
					len_d   = LEN_W'(1);
					alive_d = '1;
				end
			end else if (rx_byte_s1 != tekd_pkg::NUL_B && rx_byte_s1 != tekd_pkg::DEL_B) begin
				emit = 1'b1;
			end
		end else if (len_q >= LEN_W'(MAX_SEQ_LEN)) begin
			len_d = '0;
			emit  = 1'b1;
		end else if (!m.found) begin
			len_d = '0;
			emit  = 1'b1;
		end else if (m.complete) begin
			len_d  = '0;
			emit   = 1'b1;
			code_d = m.code;
			mods_d = m.mods;
		end else begin
			len_d   = len_q + LEN_W'(1);
			alive_d = m.alive;
		end
	end

	// Stage 1: hold the accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			rx_byte_s1 <= rx.rx_byte;
		end
	end

	// Sequence state: advance once per processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			alive_q <= '0;
		end else if (advance) begin
			len_q   <= len_d;
			alive_q <= alive_d;
		end
	end

	// Stage 2: hold the key until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			key_code_s2 <= code_d;
			mods_s2     <= mods_d;
		end
	end

	assign keys.valid     = valid_s2;
	assign keys.key_code  = key_code_s2;
	assign keys.modifiers = mods_s2;

`ifndef NO_ASSERTIONS
	// No table sequence is longer than seven bytes
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q < LEN_W'(tekd_pkg::ENTRY_SLOTS))
		else $error("sequence length beyond longest table entry");

	// An open sequence always has a live candidate
	a_alive_open: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q != '0) |-> (alive_q != '0))
		else $error("open sequence with empty match mask");

	// A processed byte that emits shows up in the result register
	a_emit_out: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit) |=> (valid_s2 && key_code_s2 == $past(code_d)))
		else $error("emitted key lost");

	// A waiting key is not replaced
	a_hold_key: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !keys.ready) |=> (valid_s2 && $stable(key_code_s2) && $stable(mods_s2)))
		else $error("pending key overwritten");
`endif

endmodule

// ----- src/tekd_match.sv -----
// Table match unit: narrows the running match mask by one byte and picks the
// first surviving key sequence. Depends on tekd_pkg.
module tekd_match (
	input  logic [tekd_pkg::BYTE_W-1:0]      rx_byte,
	input  logic [tekd_pkg::POS_W-1:0]       pos,
	input  logic [tekd_pkg::ENTRY_COUNT-1:0] alive,
	output tekd_pkg::match_t                 res
);

	logic [tekd_pkg::ENTRY_COUNT-1:0] hit;
	logic [tekd_pkg::IDX_W-1:0]       idx;
	logic                             found;
	tekd_pkg::key_entry_t             sel;

	// Keep entries that are still alive, long enough, and agree at this position
	always_comb begin
		for (int e = 0; e < tekd_pkg::ENTRY_COUNT; e++) begin
			hit[e] = alive[e] && (pos < tekd_pkg::KEY_TABLE[e].len)
				&& (tekd_pkg::KEY_TABLE[e].b[pos] == rx_byte);
		end
	end

	// Pick the lowest surviving entry
	always_comb begin
		idx   = '0;
		found = 1'b0;
		for (int e = tekd_pkg::ENTRY_COUNT - 1; e >= 0; e--) begin
			if (hit[e]) begin
				idx   = tekd_pkg::IDX_W'(e);
				found = 1'b1;
			end
		end
	end

	assign sel = tekd_pkg::KEY_TABLE[idx];

	// Complete when this byte is the entry's last one
	always_comb begin
		res.found    = found;
		res.complete = found && ({1'b0, sel.len} == ({1'b0, pos} + (tekd_pkg::POS_W + 1)'(1)));
		res.code     = sel.code;
		res.mods     = sel.mods;
		res.alive    = hit;
	end

endmodule

// ----- tb/tb_terminal_escape_key_decoder_top.sv -----
// Self-checking bench for terminal_escape_key_decoder_top: drives byte requests,
// predicts decoded keys from its own copy of the key sequence table and checks them.
// Depends on tekd_pkg, tekd_if and the decoder RTL.
module tb_terminal_escape_key_decoder_top;

	localparam int SEQ_DEPTH   = 16;
	localparam int STALL_LIMIT = 2000;
	localparam int ITEM_TARGET = 1000;
	localparam int TAIL_CYCLES = 10;
	localparam int KEY_COUNT   = 78;

	typedef enum {MATCH_NONE, MATCH_PREFIX, MATCH_FULL} match_kind_t;

	typedef tekd_pkg::byte_t byte_t;
	typedef logic [tekd_pkg::MODS_W-1:0] mods_t;

	typedef struct packed {
		byte_t              code;
		mods_t              mods;
		logic [3:0]         len;
		logic [0:6][7:0]    seq;
	} key_seq_t;

	typedef struct packed {
		byte_t              code;
		mods_t              mods;
	} key_t;

	// Tracks the open escape sequence and the keys still owed by the decoder
	class key_tracker;
		key_seq_t seq_table [KEY_COUNT];
		int       n_entries;
		byte_t    seq_buf [$];
		key_t     pending_keys [$];
		int       n_used;
		int       n_errors;

		function void add(byte_t k, mods_t m, int n, logic [0:6][7:0] s);
			seq_table[n_entries].code = k;
			seq_table[n_entries].mods = m;
			seq_table[n_entries].len  = 4'(n);
			seq_table[n_entries].seq  = s;
			n_entries++;
		endfunction

		// ESC O c, then ctrl, shift and alt forms
		function void add_ss3(byte_t k, byte_t c);
			add(k, tekd_pkg::MOD_NONE, 3, {tekd_pkg::ESC_B, tekd_pkg::SS3_B, c, 32'h0});
			add(k, tekd_pkg::MOD_CTRL, 4,
				{tekd_pkg::ESC_B, tekd_pkg::SS3_B, 8'h35, c, 24'h0});
			add(k, tekd_pkg::MOD_SHIFT, 4,
				{tekd_pkg::ESC_B, tekd_pkg::SS3_B, 8'h32, c, 24'h0});
			add(k, tekd_pkg::MOD_ALT, 4,
				{tekd_pkg::ESC_B, tekd_pkg::SS3_B, 8'h33, c, 24'h0});
		endfunction

		// ESC [ d1 d2 ~, then ctrl, shift and alt forms
		function void add_csi(byte_t k, byte_t d1, byte_t d2);
			add(k, tekd_pkg::MOD_NONE, 5,
				{tekd_pkg::ESC_B, tekd_pkg::CSI_B, d1, d2, tekd_pkg::TILDE_B, 16'h0});
			add(k, tekd_pkg::MOD_CTRL, 7, {tekd_pkg::ESC_B, tekd_pkg::CSI_B, d1, d2,
				tekd_pkg::SEMI_B, 8'h35, tekd_pkg::TILDE_B});
			add(k, tekd_pkg::MOD_SHIFT, 7, {tekd_pkg::ESC_B, tekd_pkg::CSI_B, d1, d2,
				tekd_pkg::SEMI_B, 8'h32, tekd_pkg::TILDE_B});
			add(k, tekd_pkg::MOD_ALT, 7, {tekd_pkg::ESC_B, tekd_pkg::CSI_B, d1, d2,
				tekd_pkg::SEMI_B, 8'h33, tekd_pkg::TILDE_B});
		endfunction

		// ESC [ 1 ; d f
		function void add_mod(byte_t k, mods_t m, byte_t d, byte_t f);
			add(k, m, 6, {tekd_pkg::ESC_B, tekd_pkg::CSI_B, 8'h31, tekd_pkg::SEMI_B, d, f,
				8'h0});
		endfunction

		// ESC [ d ~ and ESC [ d ; e ~
		function void add_short(byte_t k, mods_t m, byte_t d, byte_t e);
			if (m == tekd_pkg::MOD_NONE) begin
				add(k, m, 4, {tekd_pkg::ESC_B, tekd_pkg::CSI_B, d, tekd_pkg::TILDE_B, 24'h0});
			end else begin
				add(k, m, 6, {tekd_pkg::ESC_B, tekd_pkg::CSI_B, d, tekd_pkg::SEMI_B, e,
					tekd_pkg::TILDE_B, 8'h0});
			end
		endfunction

		function new();
			n_entries = 0;
			n_used    = 0;
			n_errors  = 0;
			add_ss3(8'h70, 8'h50);
			add_ss3(8'h71, 8'h51);
			add_ss3(8'h72, 8'h52);
			add_ss3(8'h73, 8'h53);
			add_csi(8'h74, 8'h31, 8'h35);
			add_csi(8'h75, 8'h31, 8'h37);
			add_csi(8'h76, 8'h31, 8'h38);
			add_csi(8'h77, 8'h31, 8'h39);
			add_csi(8'h78, 8'h32, 8'h30);
			add_csi(8'h79, 8'h32, 8'h31);
			add_csi(8'h7A, 8'h32, 8'h33);
			add_csi(8'h7B, 8'h32, 8'h34);
			add_short(8'h24, tekd_pkg::MOD_NONE, 8'h31, 8'h0);
			add_mod(8'h24, tekd_pkg::MOD_CTRL, 8'h35, 8'h48);
			add_mod(8'h24, tekd_pkg::MOD_SHIFT, 8'h32, 8'h48);
			add_mod(8'h24, tekd_pkg::MOD_ALT, 8'h33, 8'h48);
			add_short(8'h2D, tekd_pkg::MOD_NONE, 8'h32, 8'h0);
			add_short(8'h2D, tekd_pkg::MOD_CTRL, 8'h32, 8'h35);
			add_short(8'h2E, tekd_pkg::MOD_NONE, 8'h33, 8'h0);
			add_short(8'h2E, tekd_pkg::MOD_CTRL, 8'h33, 8'h35);
			add_short(8'h2E, tekd_pkg::MOD_SHIFT, 8'h33, 8'h32);
			add_short(8'h21, tekd_pkg::MOD_NONE, 8'h35, 8'h0);
			add_short(8'h21, tekd_pkg::MOD_CTRL, 8'h35, 8'h35);
			add_short(8'h21, tekd_pkg::MOD_ALT, 8'h35, 8'h33);
			add_short(8'h22, tekd_pkg::MOD_NONE, 8'h36, 8'h0);
			add_short(8'h22, tekd_pkg::MOD_CTRL, 8'h36, 8'h35);
			add_short(8'h22, tekd_pkg::MOD_ALT, 8'h36, 8'h33);
			add(8'h23, tekd_pkg::MOD_NONE, 3, {tekd_pkg::ESC_B, tekd_pkg::SS3_B, 8'h46, 32'h0});
			add_mod(8'h23, tekd_pkg::MOD_CTRL, 8'h35, 8'h46);
			add_mod(8'h23, tekd_pkg::MOD_SHIFT, 8'h32, 8'h46);
			add_mod(8'h23, tekd_pkg::MOD_ALT, 8'h33, 8'h46);
			add(8'h26, tekd_pkg::MOD_NONE, 3, {tekd_pkg::ESC_B, tekd_pkg::CSI_B, 8'h41, 32'h0});
			add_mod(8'h26, tekd_pkg::MOD_CTRL, 8'h35, 8'h41);
			add(8'h28, tekd_pkg::MOD_NONE, 3, {tekd_pkg::ESC_B, tekd_pkg::CSI_B, 8'h42, 32'h0});
			add_mod(8'h28, tekd_pkg::MOD_CTRL, 8'h35, 8'h42);
			add(8'h27, tekd_pkg::MOD_NONE, 3, {tekd_pkg::ESC_B, tekd_pkg::CSI_B, 8'h43, 32'h0});
			add_mod(8'h27, tekd_pkg::MOD_CTRL, 8'h35, 8'h43);
			add(8'h25, tekd_pkg::MOD_NONE, 3, {tekd_pkg::ESC_B, tekd_pkg::CSI_B, 8'h44, 32'h0});
			add_mod(8'h25, tekd_pkg::MOD_CTRL, 8'h35, 8'h44);
			add(8'h0D, tekd_pkg::MOD_SHIFT, 3,
				{tekd_pkg::ESC_B, tekd_pkg::SS3_B, 8'h4D, 32'h0});
			add(8'h0D, tekd_pkg::MOD_ALT, 2, {tekd_pkg::ESC_B, 8'h0D, 40'h0});
			add(8'h09, tekd_pkg::MOD_SHIFT, 3,
				{tekd_pkg::ESC_B, tekd_pkg::CSI_B, 8'h5A, 32'h0});
		endfunction

		function int pending();
			return pending_keys.size();
		endfunction

		function void push_key(byte_t k, mods_t m);
			key_t e;
			e.code = k;
			e.mods = m;
			pending_keys.push_back(e);
		endfunction

		// Scan the table in order; the first entry that agrees with the buffer decides
		function match_kind_t find_entry(output int hit);
			int  e;
			int  i;
			bit  same;
			hit = 0;
			for (e = 0; e < n_entries; e++) begin
				if (seq_buf.size() > seq_table[e].len) continue;
				same = 1'b1;
				for (i = 0; i < seq_buf.size() && i < 7; i++) begin
					if (seq_buf[i] != seq_table[e].seq[i]) begin
						same = 1'b0;
						break;
					end
				end
				if (!same) continue;
				hit = e;
				if (seq_buf.size() == seq_table[e].len) return MATCH_FULL;
				return MATCH_PREFIX;
			end
			return MATCH_NONE;
		endfunction

		// Advance the sequence state by one accepted byte request
		function void decode_byte(byte_t b);
			match_kind_t kind;
			int          hit;
			if (seq_buf.size() == 0) begin
				if (b == tekd_pkg::NUL_B || b == tekd_pkg::DEL_B) return;
				n_used++;
				if (b == tekd_pkg::ESC_B) begin
					if (SEQ_DEPTH > 1) seq_buf.push_back(b);
					return;
				end
				push_key(b, tekd_pkg::MOD_NONE);
				return;
			end
			n_used++;
			// close a full buffer and pass the byte through
			if (seq_buf.size() >= SEQ_DEPTH) begin
				seq_buf.delete();
				push_key(b, tekd_pkg::MOD_NONE);
				return;
			end
			seq_buf.push_back(b);
			kind = find_entry(hit);
			if (kind == MATCH_PREFIX) return;
			seq_buf.delete();
			if (kind == MATCH_FULL) begin
				push_key(seq_table[hit].code, seq_table[hit].mods);
			end else begin
				push_key(b, tekd_pkg::MOD_NONE);
			end
		endfunction

		function void check_key(byte_t k, mods_t m);
			key_t e;
			if (pending_keys.size() == 0) begin
				$error("unexpected key: key_code %h modifiers %h", k, m);
				n_errors++;
				return;
			end
			e = pending_keys.pop_front();
			if (k !== e.code) begin
				$error("key_code mismatch: expected %h, actual %h", e.code, k);
				n_errors++;
			end
			if (m !== e.mods) begin
				$error("modifiers mismatch: expected %h, actual %h", e.mods, m);
				n_errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   stall_cycles;
	key_tracker tracker;

	tekd_rx_if  rx_if();
	tekd_key_if key_if();

	terminal_escape_key_decoder_top #(
		.MAX_SEQ_LEN(SEQ_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_if),
		.keys(key_if)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Toggle key-side backpressure at random
	always @(negedge clk) begin
		key_if.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Note accepted byte requests, check keys, and watch for a stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_if.valid && rx_if.ready) tracker.decode_byte(rx_if.rx_byte);
			if (key_if.valid && key_if.ready) tracker.check_key(key_if.key_code, key_if.modifiers);
			if ((rx_if.valid && rx_if.ready) || (key_if.valid && key_if.ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles + 1 >= STALL_LIMIT) begin
				$display("terminal_escape_key_decoder_top verification failed");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// Drive one byte request and hold it until accepted
	task automatic send_byte(byte_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			rx_if.valid <= 1'b0;
			@(negedge clk);
		end
		rx_if.valid   <= 1'b1;
		rx_if.rx_byte <= b;
		@(posedge clk);
		while (!rx_if.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_prefix(key_seq_t e, int n);
		int i;
		for (i = 0; i < n; i++) send_byte(e.seq[i]);
	endtask

	// Drop valid and hold off until every owed key has come out
	task automatic drain_keys();
		rx_if.valid <= 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
	endtask

	// Mostly whole table sequences, some cut short or corrupted, some loose bytes
	task automatic send_random_until(int target);
		key_seq_t e;
		int       kind;
		int       n;
		int       pos;
		int       i;
		while (tracker.n_used < target) begin
			kind = $urandom_range(99);
			e = tracker.seq_table[$urandom_range(KEY_COUNT - 1)];
			if (kind < 60) begin
				send_prefix(e, e.len);
			end else if (kind < 75) begin
				n = $urandom_range(e.len - 1, 1);
				send_prefix(e, n);
				send_byte(byte_t'($urandom_range(255)));
			end else if (kind < 90) begin
				send_byte(byte_t'($urandom_range(255)));
			end else begin
				pos = $urandom_range(e.len - 1, 1);
				for (i = 0; i < e.len; i++) begin
					if (i == pos) send_byte(byte_t'($urandom_range(255)));
					else send_byte(e.seq[i]);
				end
			end
		end
	endtask

	initial begin
		byte_t directed [] = '{
			8'h00, 8'h7F, 8'hFF, 8'h01,
			8'h1B, 8'h4F, 8'h50,
			8'h1B, 8'h1B,
			8'h1B, 8'h00,
			8'h1B, 8'h7F,
			8'h1B, 8'h0D,
			8'h1B, 8'h5B, 8'h31, 8'h35, 8'h3B, 8'h35, 8'h7E,
			8'h1B, 8'h5B, 8'h31, 8'h58
		};
		tracker       = new();
		arst_n        = 1'b0;
		rx_if.valid   = 1'b0;
		rx_if.rx_byte = '0;
		key_if.ready  = 1'b0;
		stall_cycles  = 0;
		send_idle_pct = 35;
		recv_idle_pct = 85;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: field extremes, drops, escapes inside a sequence, longest entry
		foreach (directed[i]) send_byte(directed[i]);

		send_random_until(ITEM_TARGET / 3);
		drain_keys();
		@(negedge clk);

		send_idle_pct = 85;
		recv_idle_pct = 35;
		send_random_until(2 * ITEM_TARGET / 3);
		drain_keys();
		@(negedge clk);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random_until(ITEM_TARGET);

		drain_keys();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.n_errors == 0 && tracker.pending() == 0) begin
			$display("terminal_escape_key_decoder_top verification clean");
		end else begin
			$display("terminal_escape_key_decoder_top verification failed");
		end
		$finish;
	end

endmodule
